FILE: sv/lrufr_pkg.sv
// Shared types and constants for the LRU frame replacer.
package lrufr_pkg;

  localparam int unsigned NumFrames = 64;
  localparam int unsigned FrameW    = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned LvlN      = $clog2(NumFrames);

  typedef enum logic [1:0] {
    OpVictim = 2'd0,
    OpPin    = 2'd1,
    OpUnpin  = 2'd2,
    OpNop    = 2'd3
  } op_e;

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic   valid;
    op_e    op;
    frame_t frame;
  } cmd_t;

  typedef struct packed {
    logic   found;
    frame_t victim;
    count_t count;
  } res_t;

endpackage

FILE: sv/lrufr_if.sv
// Request and response channel interfaces for the LRU frame replacer.
interface lrufr_req_if import lrufr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic [1:0] opcode;
  frame_t frame_index;

  modport source (output valid, output opcode, output frame_index, input ready);
  modport sink   (input valid, input opcode, input frame_index, output ready);
endinterface

interface lrufr_rsp_if import lrufr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   found;
  frame_t victim_frame;
  count_t evictable_count;

  modport source (output valid, output found, output victim_frame,
                  output evictable_count, input ready);
  modport sink   (input valid, input found, input victim_frame,
                  input evictable_count, output ready);
endinterface

FILE: sv/lru_frame_replacer_unit.sv
// Top level of the LRU frame replacer: input stage, list cells, result register.
//
//   channel  dir  modport  word
//   req_i    in   sink     opcode, frame_index
//   rsp_o    out  source   found, victim_frame, evictable_count
//
// One request per cycle unless rsp_o stalls; each word passes s1, then res_q.
// The list update is done by 64 parallel cells (match, prefix, shift).
// Reset clears the cell valid bits and the count at once; no clearing sweep.
// A stalled response holds the result register; the input stage keeps one word.
module lru_frame_replacer_unit import lrufr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lrufr_req_if.sink    req_i,
  lrufr_rsp_if.source  rsp_o
);

  logic s1_valid_q, s1_valid_d;
  cmd_t s1_cmd_q;
  logic res_valid_q, res_valid_d;
  res_t res_q;
  res_t cell_res;
  cmd_t exec;
  logic advance, accept;

  assign advance     = s1_valid_q && (!res_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    exec       = s1_cmd_q;
    exec.valid = advance;
  end

  assign s1_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign res_valid_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : res_valid_q);

  lrufr_cells u_cells (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (exec),
    .res_o (cell_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q.valid <= 1'b1;
      s1_cmd_q.op    <= op_e'(req_i.opcode);
      s1_cmd_q.frame <= req_i.frame_index;
    end
    if (advance) begin
      res_q <= cell_res;
    end
  end

  assign rsp_o.valid           = res_valid_q;
  assign rsp_o.found           = res_q.found;
  assign rsp_o.victim_frame    = res_q.victim;
  assign rsp_o.evictable_count = res_q.count;

endmodule

FILE: sv/lrufr_cells.sv
// Ordered list cells with parallel match, shift, insert and tail removal.
module lrufr_cells import lrufr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output res_t res_o
);

  frame_t               data_q [NumFrames];
  frame_t               data_d [NumFrames];
  frame_t               data_nxt [NumFrames];
  frame_t               data_prv [NumFrames];
  logic [NumFrames-1:0] valid_q, valid_d;
  count_t               count_q, count_d;
  logic [NumFrames-1:0] match;
  logic [NumFrames-1:0] pfx [LvlN+1];
  logic                 hit, in_range;
  logic                 do_victim, do_pin, do_unpin;
  logic [FrameW-1:0]    tail_idx;
  count_t               tail_cnt;

  for (genvar g = 0; g < NumFrames; g++) begin : g_nb
    assign match[g] = valid_q[g] && (data_q[g] == cmd_i.frame);
    if (g < NumFrames - 1) begin : g_up
      assign data_nxt[g] = data_q[g+1];
    end else begin : g_top
      assign data_nxt[g] = '0;
    end
    if (g > 0) begin : g_dn
      assign data_prv[g] = data_q[g-1];
    end else begin : g_bot
      assign data_prv[g] = cmd_i.frame;
    end
  end

  // log-depth prefix OR: pfx[LvlN][i] set at and after the matching cell
  always_comb begin
    pfx[0] = match;
    for (int k = 0; k < LvlN; k++) begin
      for (int i = 0; i < NumFrames; i++) begin
        if (i >= (1 << k)) begin
          pfx[k+1][i] = pfx[k][i] | pfx[k][i - (1 << k)];
        end else begin
          pfx[k+1][i] = pfx[k][i];
        end
      end
    end
  end

  assign hit      = |match;
  assign in_range = (CountW'(cmd_i.frame) < CountW'(NumFrames));
  assign tail_cnt = count_q - count_t'(1);
  assign tail_idx = tail_cnt[FrameW-1:0];

  always_comb begin
    do_victim = 1'b0;
    do_pin    = 1'b0;
    do_unpin  = 1'b0;
    unique case (cmd_i.op)
      OpVictim: do_victim = cmd_i.valid && (count_q != '0);
      OpPin:    do_pin    = cmd_i.valid && in_range && hit;
      OpUnpin:  do_unpin  = cmd_i.valid && in_range && !hit &&
                            (count_q < count_t'(NumFrames));
      default:  ;
    endcase
  end

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    count_d = count_q;
    if (do_unpin) begin
      data_d  = data_prv;
      valid_d = {valid_q[NumFrames-2:0], 1'b1};
      count_d = count_q + count_t'(1);
    end else if (do_pin) begin
      for (int i = 0; i < NumFrames; i++) begin
        if (pfx[LvlN][i]) begin
          data_d[i] = data_nxt[i];
        end
      end
      valid_d = valid_q >> 1;
      count_d = tail_cnt;
    end else if (do_victim) begin
      valid_d = valid_q >> 1;
      count_d = tail_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign res_o.found  = do_victim;
  assign res_o.victim = do_victim ? data_q[tail_idx] : '0;
  assign res_o.count  = count_d;

  a_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_q >> 1) & ~valid_q) == '0)
    else $error("list cells not contiguous");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("count disagrees with valid cells");

  a_unpin_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_unpin |=> valid_q[0] && (data_q[0] == $past(cmd_i.frame)))
    else $error("unpinned frame not at head");

  a_pin_gone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pin |=> $countones(valid_q) == $countones($past(valid_q)) - 1)
    else $error("pin did not remove one cell");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({do_victim, do_pin, do_unpin}))
    else $error("more than one list operation");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the LRU frame replacer: directed table, then random traffic.
module tb_top import lrufr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 500_000;
  localparam int unsigned RandomWords = 1275;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned NumDirected = 25;

  typedef enum int unsigned {
    MixFill,
    MixChurn,
    MixDrain,
    MixNoise
  } mix_e;

  typedef struct packed {
    op_e    op;
    frame_t frame;
    logic   typed;
    res_t   want;
  } stim_row_t;

  // typed rows carry a hand-written answer; the others use the LRU model
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{OpVictim, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},
    '{OpNop,    6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},
    '{OpPin,    6'd5,  1'b1, '{1'b0, 6'd0,  7'd0}},
    '{OpUnpin,  6'd0,  1'b1, '{1'b0, 6'd0,  7'd1}},
    '{OpUnpin,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},
    '{OpUnpin,  6'd0,  1'b1, '{1'b0, 6'd0,  7'd2}},
    '{OpUnpin,  6'd42, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpPin,    6'd63, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpVictim, 6'd0,  1'b1, '{1'b1, 6'd0,  7'd1}},
    '{OpUnpin,  6'd21, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpUnpin,  6'd63, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpPin,    6'd21, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpNop,    6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpPin,    6'd42, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpVictim, 6'd21, 1'b1, '{1'b1, 6'd63, 7'd0}},
    '{OpVictim, 6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},
    '{OpUnpin,  6'd62, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpUnpin,  6'd1,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpPin,    6'd1,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpPin,    6'd1,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpUnpin,  6'd2,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpNop,    6'd42, 1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpVictim, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpVictim, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{OpVictim, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}}
  };

  logic clk_i;
  logic rst_ni;

  lrufr_req_if req ();
  lrufr_rsp_if rsp ();

  lru_frame_replacer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req.sink),
    .rsp_o  (rsp.source)
  );

  // model state: index 0 is the most recently unpinned frame
  frame_t      lru_order[$];
  bit          listed[NumFrames];
  res_t        pending_results[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  bit          steady_send;
  bit          hold_kick;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic res_t lru_step(op_e op, frame_t fr);
    res_t r;
    r = '0;
    case (op)
      OpVictim: begin
        if (lru_order.size() > 0) begin
          r.found  = 1'b1;
          r.victim = lru_order[$];
          lru_order.delete(lru_order.size() - 1);
          listed[r.victim] = 1'b0;
        end
      end
      OpPin: begin
        if (listed[fr]) begin
          foreach (lru_order[i]) begin
            if (lru_order[i] == fr) begin
              lru_order.delete(i);
              break;
            end
          end
          listed[fr] = 1'b0;
        end
      end
      OpUnpin: begin
        if (!listed[fr] && lru_order.size() < NumFrames) begin
          lru_order.push_front(fr);
          listed[fr] = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = count_t'(lru_order.size());
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_word(op_e op, frame_t fr, bit typed, res_t want);
    int unsigned gap;
    res_t        predicted;
    if (burst_left == 0) begin
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req.valid       <= 1'b1;
    req.opcode      <= op;
    req.frame_index <= fr;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predicted = lru_step(op, fr);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_modeled(op_e op, frame_t fr);
    send_word(op, fr, 1'b0, '0);
  endtask

  function automatic op_e pick_op(mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MixFill:  return roll < 75 ? OpUnpin : roll < 87 ? OpPin : roll < 95 ? OpVictim : OpNop;
      MixDrain: return roll < 65 ? OpVictim : roll < 80 ? OpPin : roll < 95 ? OpUnpin : OpNop;
      MixChurn: return roll < 35 ? OpUnpin : roll < 65 ? OpPin : roll < 95 ? OpVictim : OpNop;
      default:  return op_e'(roll[1:0]);
    endcase
  endfunction

  function automatic frame_t pick_frame(op_e op);
    int unsigned n;
    n = lru_order.size();
    if (n > 0 && op == OpPin && $urandom_range(0, 9) < 7)
      return lru_order[$urandom_range(0, n - 1)];
    if (n > 0 && op == OpUnpin && $urandom_range(0, 9) < 2)
      return lru_order[$urandom_range(0, n - 1)];
    return frame_t'($urandom_range(0, NumFrames - 1));
  endfunction

  // fill the whole list in shuffled order behind a long response stall, then drain it
  task automatic fill_and_drain();
    int unsigned perm[NumFrames];
    int unsigned j;
    int unsigned t;
    foreach (perm[i]) perm[i] = i;
    for (int i = NumFrames - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    steady_send = 1'b1;
    hold_kick   = 1'b1;
    foreach (perm[i]) send_modeled(OpUnpin, frame_t'(perm[i]));
    steady_send = 1'b0;
    repeat (4) send_modeled(OpUnpin, frame_t'($urandom_range(0, NumFrames - 1)));
    send_modeled(OpNop, frame_t'($urandom_range(0, NumFrames - 1)));
    repeat (NumFrames + 2) send_modeled(OpVictim, frame_t'($urandom_range(0, NumFrames - 1)));
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;
    mix_e        mix;
    op_e         op;
    rst_ni          <= 1'b0;
    req.valid       <= 1'b0;
    req.opcode      <= OpNop;
    req.frame_index <= '0;
    mismatch_cnt = 0;
    burst_left   = 0;
    steady_send  = 1'b0;
    hold_kick    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i])
      send_word(DirectedRows[i].op, DirectedRows[i].frame, DirectedRows[i].typed,
                DirectedRows[i].want);

    fill_and_drain();
    sent = 0;
    while (sent < RandomWords) begin
      mix = mix_e'($urandom_range(0, 3));
      len = $urandom_range(20, 90);
      repeat (len) begin
        op = pick_op(mix);
        send_modeled(op, pick_frame(op));
        sent++;
      end
      if ($urandom_range(0, 15) == 0) fill_and_drain();
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // response side: random stall segments, plus a long hold on request
  initial begin : response_side
    int unsigned hold_left;
    int unsigned seg_left;
    int unsigned rx_mode;
    hold_left = 0;
    seg_left  = 0;
    rx_mode   = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (hold_kick) begin
        hold_kick = 1'b0;
        hold_left = HoldCycles;
        rsp.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 100);
          rx_mode  = $urandom_range(0, 3);
        end
        seg_left--;
        case (rx_mode)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp.ready <= $urandom_range(0, 1);
          default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response word with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", rsp.found, want.found));
        if (rsp.victim_frame !== want.victim)
          report_mismatch($sformatf("victim_frame %0d, want %0d",
                                    rsp.victim_frame, want.victim));
        if (rsp.evictable_count !== want.count)
          report_mismatch($sformatf("evictable_count %0d, want %0d",
                                    rsp.evictable_count, want.count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
